>>> hw/rtl/hisd_pkg.sv
`timescale 1ns / 1ps

package hisd_pkg;

    localparam int DIM_W  = 13;
    localparam int ROWB_W = 15;
    localparam int CNT_W  = 5;

    localparam logic [31:0] MAX_DIM = 32'd4096;

    localparam int HEADER_DIGITS     = 4 * 2 * 2;
    localparam int WIDTH_LAST_DIGIT  = 7;
    localparam int HEIGHT_LAST_DIGIT = 15;
    localparam int HEX_ALPHA_BASE    = 10;

    localparam logic [7:0] CHAR_NUL       = 8'h00;
    localparam logic [7:0] CHAR_TAB       = 8'h09;
    localparam logic [7:0] CHAR_CR        = 8'h0D;
    localparam logic [7:0] CHAR_SPACE     = 8'h20;
    localparam logic [7:0] CHAR_0         = 8'h30;
    localparam logic [7:0] CHAR_9         = 8'h39;
    localparam logic [7:0] CHAR_UA        = 8'h41;
    localparam logic [7:0] CHAR_UF        = 8'h46;
    localparam logic [7:0] CHAR_LA        = 8'h61;
    localparam logic [7:0] CHAR_LF        = 8'h66;
    localparam logic [7:0] CHAR_TYPE_RGBA = 8'h41;
    localparam logic [7:0] CHAR_TYPE_RGB  = 8'h4E;

    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_BYTE   = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_BAD_TYPE  = 2'd1;
    localparam logic [1:0] ERR_EARLY_END = 2'd2;
    localparam logic [1:0] ERR_DIM_LARGE = 2'd3;

    typedef enum logic [1:0] {
        PH_SKIP,
        PH_HEAD,
        PH_DATA,
        PH_IDLE
    } phase_t;

    // {bad, nibble}; non-hex reads as zero
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [7:0] tmp;
        tmp = 8'd0;
        if (c >= CHAR_0 && c <= CHAR_9) begin
            tmp = c - CHAR_0;
            return {1'b0, tmp[3:0]};
        end
        if (c >= CHAR_LA && c <= CHAR_LF) begin
            tmp = c - CHAR_LA + 8'(HEX_ALPHA_BASE);
            return {1'b0, tmp[3:0]};
        end
        if (c >= CHAR_UA && c <= CHAR_UF) begin
            tmp = c - CHAR_UA + 8'(HEX_ALPHA_BASE);
            return {1'b0, tmp[3:0]};
        end
        return {1'b1, tmp[3:0]};
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
    endfunction

endpackage

>>> hw/rtl/hex_image_stream_decoder_core.sv
`timescale 1ns / 1ps

// channel | dir | tdata                          | tuser        | tlast
// s_      | in  | [7:0] char_code                | -            | end_of_text
// m_      | out | see m_tdata port comment       | result_kind  | last_byte
//
// One character per cycle unless m_ stalls; each passes the input register,
// then is decoded into the result register. Reset is synchronous on aresetn
// low and returns the parser to whitespace skipping. A stalled m_ holds the
// result; s_tready drops only when both input and result registers are full.

module hex_image_stream_decoder_core
    import hisd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    input  logic        s_tlast,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [1:0] error_code, [9:2] data_byte, [10] bad_digit, [11] row_end,
    // [24:12] image_width, [37:25] image_height, [38] alpha_present, [39] zero
    output logic [39:0] m_tdata,
    output logic [1:0]  m_tuser,   // [1:0] result_kind
    output logic        m_tlast,
    output logic        m_tvalid,
    input  logic        m_tready
);

    logic              in_valid_reg;
    logic [7:0]        in_char_reg;
    logic              in_end_reg;

    phase_t            phase_reg, phase_next;
    logic [CNT_W-1:0]  digit_count_reg, digit_count_next;
    logic [31:0]       header_shift_reg, header_shift_next;
    logic [DIM_W-1:0]  width_reg, width_next;
    logic [DIM_W-1:0]  height_reg, height_next;
    logic              width_big_reg, width_big_next;
    logic              height_big_reg, height_big_next;
    logic              alpha_flag_reg, alpha_flag_next;
    logic [3:0]        high_nibble_reg, high_nibble_next;
    logic              nibble_half_reg, nibble_half_next;
    logic              high_bad_reg, high_bad_next;
    logic [ROWB_W-1:0] column_count_reg, column_count_next;
    logic [DIM_W-1:0]  row_count_reg, row_count_next;
    logic [ROWB_W-1:0] row_bytes_reg, row_bytes_next;

    logic              m_valid_reg;
    logic [39:0]       m_data_reg;
    logic [1:0]        m_user_reg;
    logic              m_last_reg;

    logic              out_free, proc;
    logic              is_nul, ends, ws, in_head, head_digit, type_ok, is_rgba;
    logic              dims_big, dims_zero, rend, last;
    logic [4:0]        hex_res;
    logic [3:0]        nib;
    logic              bad;
    logic [CNT_W-1:0]  cnt_eff;
    logic [31:0]       shift_eff, shift_new;
    logic [ROWB_W-1:0] width_ext, row_bytes_calc;

    logic              res_valid, res_bad, res_rend, res_last, res_info, res_alpha;
    logic [1:0]        res_kind, res_err;
    logic [7:0]        res_byte;

    assign out_free = !m_valid_reg || m_tready;
    assign proc     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    assign is_nul     = (in_char_reg == CHAR_NUL);
    assign ends       = in_end_reg || is_nul;
    assign ws         = is_space(in_char_reg);
    assign hex_res    = hex_decode(in_char_reg);
    assign nib        = hex_res[3:0];
    assign bad        = hex_res[4];
    assign in_head    = (phase_reg == PH_HEAD) || (phase_reg == PH_SKIP && !ws);
    assign cnt_eff    = (phase_reg == PH_SKIP) ? '0 : digit_count_reg;
    assign shift_eff  = (phase_reg == PH_SKIP) ? '0 : header_shift_reg;
    assign shift_new  = {shift_eff[27:0], nib};
    assign head_digit = in_head && (cnt_eff < CNT_W'(HEADER_DIGITS));
    assign is_rgba    = (in_char_reg == CHAR_TYPE_RGBA);
    assign type_ok    = is_rgba || (in_char_reg == CHAR_TYPE_RGB);
    assign dims_big   = width_big_reg || height_big_reg;
    assign dims_zero  = (width_reg == '0) || (height_reg == '0);
    assign rend       = (column_count_reg + ROWB_W'(1)) == row_bytes_reg;
    assign last       = rend && ((row_count_reg + DIM_W'(1)) == height_reg);

    assign width_ext      = ROWB_W'(width_reg);
    assign row_bytes_calc = is_rgba ? (width_ext << 2) : (width_ext + (width_ext << 1));

    always_comb begin
        phase_next = phase_reg;
        if (proc) begin
            if (ends) begin
                phase_next = PH_SKIP;
            end else begin
                unique case (phase_reg)
                    PH_SKIP: begin
                        if (!ws) phase_next = PH_HEAD;
                    end
                    PH_HEAD: begin
                        if (!head_digit) begin
                            if (!type_ok || dims_big || dims_zero) phase_next = PH_IDLE;
                            else phase_next = PH_DATA;
                        end
                    end
                    PH_DATA: begin
                        if (nibble_half_reg && last) phase_next = PH_IDLE;
                    end
                    PH_IDLE: begin
                        phase_next = PH_IDLE;
                    end
                    default: phase_next = PH_SKIP;
                endcase
            end
        end
    end

    always_comb begin
        res_valid = 1'b0;
        res_kind  = KIND_HEADER;
        res_err   = ERR_NONE;
        res_byte  = '0;
        res_bad   = 1'b0;
        res_rend  = 1'b0;
        res_last  = 1'b0;
        res_info  = 1'b0;
        res_alpha = 1'b0;
        if (proc) begin
            if (is_nul) begin
                if (phase_reg != PH_IDLE) begin
                    res_valid = 1'b1;
                    res_kind  = KIND_ERROR;
                    res_err   = ERR_EARLY_END;
                end
            end else begin
                unique case (phase_reg)
                    PH_SKIP, PH_HEAD: begin
                        if (!in_head || head_digit) begin
                            if (ends) begin
                                res_valid = 1'b1;
                                res_kind  = KIND_ERROR;
                                res_err   = ERR_EARLY_END;
                            end
                        end else begin
                            res_valid = 1'b1;
                            priority if (!type_ok) begin
                                res_kind = KIND_ERROR;
                                res_err  = ERR_BAD_TYPE;
                            end else if (dims_big) begin
                                res_kind = KIND_ERROR;
                                res_err  = ERR_DIM_LARGE;
                            end else if (dims_zero || !ends) begin
                                res_kind  = KIND_HEADER;
                                res_info  = 1'b1;
                                res_alpha = is_rgba;
                            end else begin
                                res_kind = KIND_ERROR;
                                res_err  = ERR_EARLY_END;
                            end
                        end
                    end
                    PH_DATA: begin
                        if (!nibble_half_reg || !last) begin
                            if (ends) begin
                                res_valid = 1'b1;
                                res_kind  = KIND_ERROR;
                                res_err   = ERR_EARLY_END;
                            end
                        end
                        if (nibble_half_reg && (!ends || last)) begin
                            res_valid = 1'b1;
                            res_kind  = KIND_BYTE;
                            res_byte  = {high_nibble_reg, nib};
                            res_bad   = high_bad_reg || bad;
                            res_rend  = rend;
                            res_last  = last;
                            res_info  = 1'b1;
                            res_alpha = alpha_flag_reg;
                        end
                    end
                    PH_IDLE: begin
                        res_valid = 1'b0;
                    end
                    default: res_valid = 1'b0;
                endcase
            end
        end
    end

    always_comb begin
        digit_count_next  = digit_count_reg;
        header_shift_next = header_shift_reg;
        width_next        = width_reg;
        height_next       = height_reg;
        width_big_next    = width_big_reg;
        height_big_next   = height_big_reg;
        alpha_flag_next   = alpha_flag_reg;
        high_nibble_next  = high_nibble_reg;
        nibble_half_next  = nibble_half_reg;
        high_bad_next     = high_bad_reg;
        column_count_next = column_count_reg;
        row_count_next    = row_count_reg;
        row_bytes_next    = row_bytes_reg;
        if (proc) begin
            if (ends) begin
                digit_count_next  = '0;
                header_shift_next = '0;
                width_next        = '0;
                height_next       = '0;
                width_big_next    = 1'b0;
                height_big_next   = 1'b0;
                alpha_flag_next   = 1'b0;
                high_nibble_next  = '0;
                nibble_half_next  = 1'b0;
                high_bad_next     = 1'b0;
                column_count_next = '0;
                row_count_next    = '0;
                row_bytes_next    = '0;
            end else if (head_digit) begin
                header_shift_next = shift_new;
                digit_count_next  = cnt_eff + CNT_W'(1);
                if (cnt_eff == CNT_W'(WIDTH_LAST_DIGIT)) begin
                    width_next     = shift_new[DIM_W-1:0];
                    width_big_next = shift_new > MAX_DIM;
                end
                if (cnt_eff == CNT_W'(HEIGHT_LAST_DIGIT)) begin
                    height_next     = shift_new[DIM_W-1:0];
                    height_big_next = shift_new > MAX_DIM;
                end
            end else if (in_head) begin
                if (type_ok) begin
                    alpha_flag_next = is_rgba;
                    if (!dims_big && !dims_zero) begin
                        nibble_half_next  = 1'b0;
                        column_count_next = '0;
                        row_count_next    = '0;
                        row_bytes_next    = row_bytes_calc;
                    end
                end
            end else if (phase_reg == PH_DATA) begin
                if (!nibble_half_reg) begin
                    high_nibble_next = nib;
                    high_bad_next    = bad;
                    nibble_half_next = 1'b1;
                end else begin
                    nibble_half_next = 1'b0;
                    if (rend) begin
                        column_count_next = '0;
                        row_count_next    = row_count_reg + DIM_W'(1);
                    end else begin
                        column_count_next = column_count_reg + ROWB_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg     <= 1'b0;
            m_valid_reg      <= 1'b0;
            phase_reg        <= PH_SKIP;
            digit_count_reg  <= '0;
            header_shift_reg <= '0;
            width_reg        <= '0;
            height_reg       <= '0;
            width_big_reg    <= 1'b0;
            height_big_reg   <= 1'b0;
            alpha_flag_reg   <= 1'b0;
            high_nibble_reg  <= '0;
            nibble_half_reg  <= 1'b0;
            high_bad_reg     <= 1'b0;
            column_count_reg <= '0;
            row_count_reg    <= '0;
            row_bytes_reg    <= '0;
        end else begin
            if (s_tready) in_valid_reg <= s_tvalid;
            if (out_free) m_valid_reg <= res_valid;
            phase_reg        <= phase_next;
            digit_count_reg  <= digit_count_next;
            header_shift_reg <= header_shift_next;
            width_reg        <= width_next;
            height_reg       <= height_next;
            width_big_reg    <= width_big_next;
            height_big_reg   <= height_big_next;
            alpha_flag_reg   <= alpha_flag_next;
            high_nibble_reg  <= high_nibble_next;
            nibble_half_reg  <= nibble_half_next;
            high_bad_reg     <= high_bad_next;
            column_count_reg <= column_count_next;
            row_count_reg    <= row_count_next;
            row_bytes_reg    <= row_bytes_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_char_reg <= s_tdata;
            in_end_reg  <= s_tlast;
        end
        if (res_valid) begin
            m_user_reg <= res_kind;
            m_last_reg <= res_last;
            m_data_reg <= {1'b0,
                           res_alpha,
                           res_info ? height_reg : DIM_W'(0),
                           res_info ? width_reg : DIM_W'(0),
                           res_rend, res_bad, res_byte, res_err};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

`ifndef NO_ASSERTIONS
    a_data_phase_sane: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_DATA |-> !width_big_reg && !height_big_reg && row_bytes_reg != '0)
        else $error("data phase entered with invalid dimensions");

    a_error_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_ERROR |-> m_tdata[1:0] != ERR_NONE
            && m_tdata[38:2] == '0 && !m_tlast)
        else $error("error result carries payload");

    a_nonbyte_marks: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != KIND_BYTE |-> !m_tlast && m_tdata[11:2] == '0)
        else $error("byte marks on non-byte result");

    a_stall_keeps_input: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !out_free |=> in_valid_reg && $stable(in_char_reg))
        else $error("input transaction dropped during stall");
`endif

endmodule
